// ===== hw/rtl/nmb_pkg.sv =====
`timescale 1ns / 1ps

package nmb_pkg;

  localparam int CH_W  = 8;
  localparam int CFG_W = 11;
  localparam int IDX_W = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_ROUNDS = 4;

  localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);
  localparam logic [CFG_W-1:0] RST_ROUNDS = CFG_W'(1);

  typedef enum logic [IDX_W-1:0] {
    IDX_WIDTH  = 2'd0,
    IDX_HEIGHT = 2'd1,
    IDX_ROUNDS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // one request travelling down the chain
  typedef struct packed {
    pixel_t pix;
    logic   last;
  } tok_t;

endpackage

// ===== hw/rtl/nmb_if.sv =====
`timescale 1ns / 1ps

interface nmb_in_if;
  logic                     valid;
  logic                     ready;
  logic [nmb_pkg::CH_W-1:0] red_in;
  logic [nmb_pkg::CH_W-1:0] green_in;
  logic [nmb_pkg::CH_W-1:0] blue_in;
  logic                     filler;

  modport source (output valid, red_in, green_in, blue_in, filler, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, filler, output ready);
endinterface

interface nmb_out_if;
  logic                     valid;
  logic                     ready;
  logic [nmb_pkg::CH_W-1:0] red_out;
  logic [nmb_pkg::CH_W-1:0] green_out;
  logic [nmb_pkg::CH_W-1:0] blue_out;
  logic                     frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ===== hw/rtl/neighbour_mean_blur_rgb.sv =====
`timescale 1ns / 1ps

// Eight-neighbour mean blur on a raster RGB stream, one pixel request per clock
// sustained while the output is not stalled. Each blur round is one chain cell
// with two line stores (single write port, registered read) and a 3x3 window;
// cells past round_count pass pixels through. Results trail the input by
// round_count*(width+1) requests, so after the last pixel of a frame send that
// many filler requests to drain it; fillers sent before the frame is complete
// are dropped. Each cell registers a request in stage A and then in its output
// register. Write configuration only while idle; any write restarts the frame.
module neighbour_mean_blur_rgb #(
  parameter int MAX_WIDTH  = nmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = nmb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_ROUNDS = nmb_pkg::DEF_MAX_ROUNDS
) (
  input  logic                           clk,
  input  logic                           rst,
  nmb_in_if.sink                         pix_in,
  nmb_out_if.source                      pix_out,
  input  logic                           write_en,
  input  logic [nmb_pkg::IDX_W-1:0]      reg_index,
  input  logic [nmb_pkg::CFG_W-1:0]      write_data
);
  import nmb_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int HCW  = $clog2(MAX_HEIGHT);
  localparam int DW   = $clog2(MAX_WIDTH+1);
  localparam int HDW  = $clog2(MAX_HEIGHT+1);
  localparam int RDW  = $clog2(MAX_ROUNDS+1);
  localparam int DCW  = $clog2(MAX_ROUNDS*(MAX_WIDTH+1)+1);
  localparam int CMPW = ((DW > HDW ? DW : HDW) > CFG_W ? (DW > HDW ? DW : HDW) : CFG_W) + 1;

  logic [CFG_W-1:0] width_reg, height_reg, rounds_reg;
  logic [DW-1:0]    w_eff;
  logic [HDW-1:0]   h_eff;
  logic [RDW-1:0]   r_eff;
  logic [DCW-1:0]   drain_len;

  logic [CW-1:0]    in_col;
  logic [HCW-1:0]   in_row;
  logic [DCW-1:0]   dcnt;
  logic             draining;
  logic             advance, take, tok_last, end_pix;
  tok_t             in_tok;

  logic             chain_valid [MAX_ROUNDS+1];
  tok_t             chain_tok [MAX_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= RST_WIDTH;
      height_reg <= RST_HEIGHT;
      rounds_reg <= RST_ROUNDS;
    end else if (write_en) begin
      case (reg_index)
        IDX_WIDTH:  width_reg  <= write_data;
        IDX_HEIGHT: height_reg <= write_data;
        IDX_ROUNDS: rounds_reg <= write_data & CFG_W'(7);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_reg == '0) begin
      w_eff = DW'(1);
    end else if (CMPW'(width_reg) > CMPW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(width_reg);
    end
    if (height_reg == '0) begin
      h_eff = HDW'(1);
    end else if (CMPW'(height_reg) > CMPW'(MAX_HEIGHT)) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = HDW'(height_reg);
    end
    if (CMPW'(rounds_reg) > CMPW'(MAX_ROUNDS)) begin
      r_eff = RDW'(MAX_ROUNDS);
    end else begin
      r_eff = RDW'(rounds_reg);
    end
  end

  assign drain_len = DCW'(r_eff) * (DCW'(w_eff) + DCW'(1));

  assign advance      = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = advance;
  assign take         = pix_in.valid && advance && (draining || !pix_in.filler);
  assign end_pix      = !draining && (in_col == CW'(w_eff - DW'(1))) &&
                        (in_row == HCW'(h_eff - HDW'(1)));
  assign tok_last     = draining ? (dcnt == drain_len - DCW'(1))
                                 : (end_pix && (r_eff == '0));

  always_comb begin
    in_tok.pix.red   = draining ? '0 : pix_in.red_in;
    in_tok.pix.green = draining ? '0 : pix_in.green_in;
    in_tok.pix.blue  = draining ? '0 : pix_in.blue_in;
    in_tok.last      = tok_last;
  end

  always_ff @(posedge clk) begin
    if (rst || write_en) begin
      in_col   <= '0;
      in_row   <= '0;
      dcnt     <= '0;
      draining <= 1'b0;
    end else if (take) begin
      if (tok_last) begin
        in_col   <= '0;
        in_row   <= '0;
        dcnt     <= '0;
        draining <= 1'b0;
      end else if (draining) begin
        dcnt <= dcnt + DCW'(1);
      end else if (end_pix) begin
        draining <= 1'b1;
        dcnt     <= '0;
      end else if (in_col == CW'(w_eff - DW'(1))) begin
        in_col <= '0;
        in_row <= in_row + HCW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  assign chain_valid[0] = take;
  assign chain_tok[0]   = in_tok;

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_cell
    nmb_cell #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_ROUNDS (MAX_ROUNDS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .clear     (write_en),
      .active    (RDW'(k) < r_eff),
      .frame_w   (w_eff),
      .frame_h   (h_eff),
      .in_valid  (chain_valid[k]),
      .in_tok    (chain_tok[k]),
      .out_valid (chain_valid[k+1]),
      .out_tok   (chain_tok[k+1])
    );
  end

  assign pix_out.valid     = chain_valid[MAX_ROUNDS];
  assign pix_out.red_out   = chain_tok[MAX_ROUNDS].pix.red;
  assign pix_out.green_out = chain_tok[MAX_ROUNDS].pix.green;
  assign pix_out.blue_out  = chain_tok[MAX_ROUNDS].pix.blue;
  assign pix_out.frame_end = chain_tok[MAX_ROUNDS].last;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && !pix_out.ready |-> !pix_in.ready)
    else $error("input taken while output stalled");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    write_en |=> !draining && in_col == '0 && in_row == '0 && dcnt == '0)
    else $error("config write did not restart frame");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    take && tok_last && !write_en |=> !draining && in_col == '0 && in_row == '0)
    else $error("frame counters not cleared after last request");

  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    draining |-> dcnt < drain_len)
    else $error("drain count overran");

endmodule

// ===== hw/rtl/nmb_cell.sv =====
`timescale 1ns / 1ps

module nmb_cell #(
  parameter int MAX_WIDTH  = nmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = nmb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_ROUNDS = nmb_pkg::DEF_MAX_ROUNDS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                clear,
  input  logic                                active,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      frame_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     frame_h,
  input  logic                                in_valid,
  input  nmb_pkg::tok_t                       in_tok,
  output logic                                out_valid,
  output nmb_pkg::tok_t                       out_tok
);
  import nmb_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int DW  = $clog2(MAX_WIDTH+1);
  localparam int DW1 = DW + 1;
  localparam int RW  = $clog2(MAX_HEIGHT + 2*MAX_ROUNDS + 4);

  function automatic logic [CH_W-1:0] chan_mean(
    input logic [CH_W-1:0] a, b, c, d, e, f, g, h);
    logic [CH_W+2:0] sum;
    sum = (CH_W+3)'(a) + (CH_W+3)'(b) + (CH_W+3)'(c) + (CH_W+3)'(d)
        + (CH_W+3)'(e) + (CH_W+3)'(f) + (CH_W+3)'(g) + (CH_W+3)'(h);
    return sum[CH_W+2:3];
  endfunction

  // push and emit position counters
  logic [CW-1:0] pc, pc_next, qc, qc_next;
  logic [RW-1:0] pr, pr_next, qr, qr_next;
  logic          entry, emit_in, int_in, beyond_in;
  logic          pc_wrap, qc_wrap;

  // stage A
  logic          a_valid;
  tok_t          a_tok;
  logic          a_emit, a_int, a_beyond;
  logic [CW-1:0] a_col;
  pixel_t        rd0, rd1;

  pixel_t        line0 [MAX_WIDTH];
  pixel_t        line1 [MAX_WIDTH];
  pixel_t        win [3][3];
  pixel_t        mean_pix, result;
  logic          fwd;

  assign entry   = advance && in_valid && active;
  assign pc_wrap = (pc == CW'(frame_w - DW'(1)));
  assign qc_wrap = (qc == CW'(frame_w - DW'(1)));
  assign emit_in = (pr >= RW'(2)) || ((pr == RW'(1)) && (pc != '0));
  assign int_in  = (qr >= RW'(1)) && ((qr + RW'(2)) <= RW'(frame_h)) &&
                   (qc != '0) && ((DW1'(qc) + DW1'(2)) <= DW1'(frame_w));
  assign beyond_in = (qr >= RW'(frame_h));

  always_comb begin
    pc_next = pc;
    pr_next = pr;
    qc_next = qc;
    qr_next = qr;
    if (clear) begin
      pc_next = '0;
      pr_next = '0;
      qc_next = '0;
      qr_next = '0;
    end else if (entry) begin
      if (in_tok.last) begin
        pc_next = '0;
        pr_next = '0;
        qc_next = '0;
        qr_next = '0;
      end else begin
        pc_next = pc_wrap ? '0 : pc + CW'(1);
        pr_next = pc_wrap ? pr + RW'(1) : pr;
        if (emit_in) begin
          qc_next = qc_wrap ? '0 : qc + CW'(1);
          qr_next = qc_wrap ? qr + RW'(1) : qr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      pr <= '0;
      qc <= '0;
      qr <= '0;
    end else begin
      pc <= pc_next;
      pr <= pr_next;
      qc <= qc_next;
      qr <= qr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= in_valid;
      out_valid <= a_valid && (a_emit || !active);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      a_tok    <= in_tok;
      a_emit   <= emit_in;
      a_int    <= int_in;
      a_beyond <= beyond_in;
      a_col    <= pc;
    end
    if (advance && a_valid) begin
      out_tok.pix  <= active ? result : a_tok.pix;
      out_tok.last <= a_tok.last;
    end
  end

  // same column written and read in one cycle: one-pixel rows, or a frame restart
  assign fwd = a_valid && (a_col == pc);

  always_ff @(posedge clk) begin
    if (advance && active) begin
      if (a_valid) begin
        line1[a_col] <= rd0;
        line0[a_col] <= a_tok.pix;
      end
      if (in_valid) begin
        rd0 <= fwd ? a_tok.pix : line0[pc];
        rd1 <= fwd ? rd0 : line1[pc];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (advance && active && a_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd1;
      win[1][2] <= rd0;
      win[2][2] <= a_tok.pix;
    end
  end

  // neighbours of the window after this shift; the centre is win[1][2]
  always_comb begin
    mean_pix.red   = chan_mean(win[0][1].red, win[0][2].red, rd1.red, win[1][1].red,
                               rd0.red, win[2][1].red, win[2][2].red, a_tok.pix.red);
    mean_pix.green = chan_mean(win[0][1].green, win[0][2].green, rd1.green,
                               win[1][1].green, rd0.green, win[2][1].green,
                               win[2][2].green, a_tok.pix.green);
    mean_pix.blue  = chan_mean(win[0][1].blue, win[0][2].blue, rd1.blue, win[1][1].blue,
                               rd0.blue, win[2][1].blue, win[2][2].blue, a_tok.pix.blue);
    if (a_beyond) begin
      result = '0;
    end else if (a_int) begin
      result = mean_pix;
    end else begin
      result = win[1][2];
    end
  end

endmodule

// ===== tb/neighbour_mean_blur_rgb_tb.sv =====
`timescale 1ns / 1ps

module neighbour_mean_blur_rgb_tb;
  import nmb_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXH = DEF_MAX_HEIGHT;
  localparam int MAXR = DEF_MAX_ROUNDS;
  localparam int SETTLE = 2 * MAXR + 8;
  localparam int LIMIT = 600000;
  localparam int RANDOM_ITEMS = 600;
  localparam logic [IDX_W-1:0] IDX_SPARE = 2'd3;

  typedef struct {
    pixel_t px;
    bit     fill;
    bit     typed;
    pixel_t want;
    bit     want_last;
  } dir_row_t;

  typedef struct packed {
    pixel_t px;
    logic   last;
  } blur_res_t;

  logic clk = 1'b0;
  logic rst;
  logic write_en;
  logic [IDX_W-1:0] reg_index;
  logic [CFG_W-1:0] write_data;

  nmb_in_if  in_ch ();
  nmb_out_if out_ch ();

  neighbour_mean_blur_rgb dut (
    .clk(clk), .rst(rst), .pix_in(in_ch), .pix_out(out_ch),
    .write_en(write_en), .reg_index(reg_index), .write_data(write_data)
  );

  always #2 clk = ~clk;

  // blur predictor state
  logic [23:0] line_mem [MAXR][2][MAXW];
  logic [23:0] win [MAXR][3][3];
  int unsigned taken;
  int unsigned cfg_w, cfg_h, cfg_r;

  blur_res_t pending_px [$];
  int unsigned n_items, n_results, n_frames, n_bad, cycles;
  int burst_left;
  logic [7:0] stall_pat = 8'hFF;

  function automatic bit blur_predict(input pixel_t px, input bit fill,
                                      output blur_res_t res);
    int unsigned w, h, r, total, span, a, p, q, o, col, sum;
    logic [23:0] v, top, mid;
    w = (cfg_w < 1) ? 1 : ((cfg_w > MAXW) ? MAXW : cfg_w);
    h = (cfg_h < 1) ? 1 : ((cfg_h > MAXH) ? MAXH : cfg_h);
    r = (cfg_r > MAXR) ? MAXR : cfg_r;
    total = w * h;
    span = w + 1;
    res = '0;
    if (taken < total) begin
      if (fill) return 1'b0;
      v = px;
    end else begin
      v = '0;
    end
    a = taken;
    taken++;
    for (int k = 0; k < r; k++) begin
      if (a < k * span) return 1'b0;
      p = a - k * span;
      col = p % w;
      top = line_mem[k][1][col];
      mid = line_mem[k][0][col];
      line_mem[k][1][col] = mid;
      line_mem[k][0][col] = v;
      for (int rr = 0; rr < 3; rr++) begin
        win[k][rr][0] = win[k][rr][1];
        win[k][rr][1] = win[k][rr][2];
      end
      win[k][0][2] = top;
      win[k][1][2] = mid;
      win[k][2][2] = v;
      if (p < span) return 1'b0;
      q = p - span;
      if (q >= total) begin
        v = '0;
      end else if (q / w >= 1 && q / w + 2 <= h && q % w >= 1 && q % w + 2 <= w) begin
        // centre left out of the mean
        for (int ch = 0; ch < 3; ch++) begin
          sum = 0;
          for (int rr = 0; rr < 3; rr++)
            for (int cc = 0; cc < 3; cc++)
              if (rr != 1 || cc != 1) sum += win[k][rr][cc][ch*8 +: 8];
          v[ch*8 +: 8] = 8'(sum >> 3);
        end
      end else begin
        v = win[k][1][1];
      end
    end
    o = a - r * span;
    res.px = v;
    res.last = (o + 1 == total);
    if (o + 1 >= total) taken = 0;
    return 1'b1;
  endfunction

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input int unsigned val);
    write_en <= 1'b1;
    reg_index <= idx;
    write_data <= CFG_W'(val);
    @(posedge clk);
    write_en <= 1'b0;
    case (idx)
      IDX_WIDTH:  cfg_w = val & 11'h7FF;
      IDX_HEIGHT: cfg_h = val & 11'h7FF;
      IDX_ROUNDS: cfg_r = val & 3'h7;
      default: ;
    endcase
    taken = 0;
  endtask

  task automatic send_px(input pixel_t px, input bit fill, input bit typed = 1'b0,
                         input pixel_t want = '0, input bit want_last = 1'b0);
    blur_res_t res;
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.red_in <= px.red;
    in_ch.green_in <= px.green;
    in_ch.blue_in <= px.blue;
    in_ch.filler <= fill;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
    burst_left--;
    if (blur_predict(px, fill, res)) begin
      if (typed) begin
        res.px = want;
        res.last = want_last;
      end
      pending_px.push_back(res);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_frames(input int unsigned w, input int unsigned h,
                            input int unsigned r, input int nframes,
                            input bit noisy, input bit hold_mid);
    int unsigned ew, eh, er;
    ew = (w < 1) ? 1 : ((w > MAXW) ? MAXW : w);
    eh = (h < 1) ? 1 : ((h > MAXH) ? MAXH : h);
    er = (r > MAXR) ? MAXR : r;
    for (int f = 0; f < nframes; f++) begin
      for (int i = 0; i < ew * eh; i++) begin
        if (noisy && $urandom_range(0, 15) == 0)
          send_px(pixel_t'(24'($urandom)), 1'b1);
        // drop the rest of the frame now and then
        if (noisy && $urandom_range(0, 399) == 0) return;
        if (hold_mid && f == 0 && i == ew * eh / 2) begin
          in_ch.valid <= 1'b0;
          burst_left = 0;
          while (pending_px.size() != 0) @(posedge clk);
        end
        send_px(pixel_t'(24'($urandom)), 1'b0);
      end
      for (int i = 0; i < er * (ew + 1); i++)
        send_px(pixel_t'(24'($urandom)), noisy ? 1'($urandom) : 1'b1);
      n_frames++;
    end
  endtask

  always @(posedge clk) begin
    blur_res_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_px.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected pixel %h last %b", {out_ch.red_out, out_ch.green_out,
                   out_ch.blue_out}, out_ch.frame_end);
      end else begin
        want = pending_px.pop_front();
        if (out_ch.red_out !== want.px.red || out_ch.green_out !== want.px.green ||
            out_ch.blue_out !== want.px.blue || out_ch.frame_end !== want.last) begin
          n_bad++;
          if (n_bad <= 10)
            $display("pixel mismatch: want %h/%h/%h last %b, got %h/%h/%h last %b",
                     want.px.red, want.px.green, want.px.blue, want.last,
                     out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.frame_end);
        end
      end
    end
  end

  // receiver stall pattern: a rotating ready mask, all ones or random when refreshed
  always @(posedge clk) begin
    if (cycles % 128 == 0)
      stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
    else
      stall_pat <= {stall_pat[0], stall_pat[7:1]};
    out_ch.ready <= stall_pat[0];
  end

  dir_row_t pass_rows [5];
  dir_row_t blur_rows [13];

  initial begin
    int unsigned start;
    rst <= 1'b1;
    write_en <= 1'b0;
    reg_index <= '0;
    write_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.red_in <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in <= '0;
    in_ch.filler <= 1'b0;
    cfg_w = RST_WIDTH;
    cfg_h = RST_HEIGHT;
    cfg_r = RST_ROUNDS;
    taken = 0;
    burst_left = 0;
    for (int k = 0; k < MAXR; k++)
      for (int rr = 0; rr < 3; rr++)
        for (int cc = 0; cc < 3; cc++) win[k][rr][cc] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero rounds: every pixel straight through, early filler dropped
    pass_rows = '{
      '{24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
      '{24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0},
      '{24'h80017F, 1'b1, 1'b0, 24'h000000, 1'b0},
      '{24'hAA55F0, 1'b0, 1'b1, 24'hAA55F0, 1'b0},
      '{24'h010203, 1'b0, 1'b1, 24'h010203, 1'b1}};
    cfg_write(IDX_WIDTH, 4);
    cfg_write(IDX_HEIGHT, 1);
    cfg_write(IDX_ROUNDS, 0);
    foreach (pass_rows[i])
      send_px(pass_rows[i].px, pass_rows[i].fill, pass_rows[i].typed,
              pass_rows[i].want, pass_rows[i].want_last);
    wait_drained();

    // one round on 3x3: borders kept, centre takes the mean of its ring
    blur_rows = '{
      '{24'hFF0080, 1'b0, 1'b0, 24'h0, 1'b0},
      '{24'hFF0080, 1'b0, 1'b0, 24'h0, 1'b0},
      '{24'hFF0080, 1'b0, 1'b0, 24'h0, 1'b0},
      '{24'hFF0080, 1'b0, 1'b0, 24'h0, 1'b0},
      '{24'h123456, 1'b0, 1'b1, 24'hFF0080, 1'b0},
      '{24'hFF0080, 1'b0, 1'b1, 24'hFF0080, 1'b0},
      '{24'hFF0080, 1'b0, 1'b1, 24'hFF0080, 1'b0},
      '{24'hFF0080, 1'b0, 1'b1, 24'hFF0080, 1'b0},
      '{24'hFF0080, 1'b0, 1'b1, 24'hFF0080, 1'b0},
      '{24'h000000, 1'b1, 1'b1, 24'hFF0080, 1'b0},
      '{24'h000000, 1'b1, 1'b1, 24'hFF0080, 1'b0},
      '{24'h000000, 1'b1, 1'b1, 24'hFF0080, 1'b0},
      '{24'h000000, 1'b1, 1'b1, 24'hFF0080, 1'b1}};
    cfg_write(IDX_WIDTH, 3);
    cfg_write(IDX_HEIGHT, 3);
    cfg_write(IDX_ROUNDS, 1);
    foreach (blur_rows[i])
      send_px(blur_rows[i].px, blur_rows[i].fill, blur_rows[i].typed,
              blur_rows[i].want, blur_rows[i].want_last);
    wait_drained();

    start = n_items;
    while (n_items - start < RANDOM_ITEMS) begin
      int unsigned w, h, r;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) % 12 : $urandom_range(1, 9);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 9);
      r = $urandom_range(0, 7);
      if ($urandom_range(0, 5) == 0) cfg_write(IDX_SPARE, $urandom_range(0, 2047));
      cfg_write(IDX_WIDTH, w);
      cfg_write(IDX_HEIGHT, h);
      cfg_write(IDX_ROUNDS, r);
      run_frames(w, h, r, $urandom_range(1, 3), 1'b1, n_items - start < 100);
      wait_drained();
    end

    // widest frame, saturated width register
    cfg_write(IDX_WIDTH, 2047);
    cfg_write(IDX_HEIGHT, 1);
    cfg_write(IDX_ROUNDS, 0);
    run_frames(2047, 1, 0, 1, 1'b0, 1'b0);
    wait_drained();

    $display("ran %0d pixel requests over %0d frames, %0d blurred pixels checked",
             n_items, n_frames, n_results);
    $display("small frames with zero to saturated rounds, plus one saturated 1024-wide row");
    if (n_bad == 0 && pending_px.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== neighbour_mean_blur_rgb.f =====
hw/rtl/nmb_pkg.sv
hw/rtl/nmb_if.sv
hw/rtl/nmb_cell.sv
hw/rtl/neighbour_mean_blur_rgb.sv
tb/neighbour_mean_blur_rgb_tb.sv
